// ===== hdl/gated_greedy_min_assignment_top_assert.svh =====
// Assertion macros shared by the gated greedy assignment RTL.
`ifndef GATED_GREEDY_MIN_ASSIGNMENT_TOP_ASSERT_SVH
`define GATED_GREEDY_MIN_ASSIGNMENT_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GGMA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define GGMA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ggma_pkg.sv =====
// Package: constants, register indexes and state type of the greedy assignment block.
package ggma_pkg;

   // default matrix bounds and result limit
   localparam int GGMA_MAX_ROWS    = 16;
   localparam int GGMA_MAX_COLS    = 16;
   localparam int GGMA_MAX_RESULTS = 16;

   // field widths
   localparam int DIM_W   = 5;
   localparam int SEL_W   = 4;
   localparam int SCORE_W = 16;
   localparam int CNT_W   = 5;
   localparam int CSR_W   = 2;

   // configuration register indexes
   typedef enum logic [CSR_W-1:0] {
      CSR_NUM_ROWS   = 2'd0,
      CSR_NUM_COLS   = 2'd1,
      CSR_MATCH_GATE = 2'd2
   } csr_index_type;

   // input commands
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_START = 1'b1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TAIL,
      ST_DECIDE,
      ST_FINAL
   } ggma_state_type;

endpackage

// ===== hdl/gated_greedy_min_assignment_top.sv =====
// Greedy gated minimum assignment: score memory, pass sequencer and result register.
// Load words (cmd=0) are taken one per cycle and written straight into the score memory.
// A start word (cmd=1) runs passes over the active rows x cols area; each pass reads
// every entry through the single read port of the score memory, one entry per cycle.
// A run makes one pass per match plus one more pass that finds nothing (that pass is
// skipped when the match limit is reached, and the final match is then sent from the
// FINAL state). An empty matrix goes straight to the decide state and answers with a
// no-match result. Results wait in an output register; a stalled result holds the
// sequencer only when the next result is ready. New words are refused (req_stall
// high) for the whole run.
module gated_greedy_min_assignment_top #(
   parameter int MAX_ROWS = ggma_pkg::GGMA_MAX_ROWS,
   parameter int MAX_COLS = ggma_pkg::GGMA_MAX_COLS
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_cmd,
   input  logic [ggma_pkg::SEL_W-1:0]   req_row_sel,
   input  logic [ggma_pkg::SEL_W-1:0]   req_col_sel,
   input  logic [ggma_pkg::SCORE_W-1:0] req_score,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ggma_pkg::SEL_W-1:0]   rsp_match_row,
   output logic [ggma_pkg::SEL_W-1:0]   rsp_match_col,
   output logic                         rsp_found,
   output logic [ggma_pkg::CNT_W-1:0]   rsp_match_count,
   output logic                         rsp_last,
   // configuration write channel
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [ggma_pkg::CSR_W-1:0]   csr_index,
   input  logic [ggma_pkg::SCORE_W-1:0] csr_wdata
);

   `include "gated_greedy_min_assignment_top_assert.svh"

   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RCW   = $clog2(MAX_ROWS + 1);
   localparam int CCW   = $clog2(MAX_COLS + 1);
   localparam int LW    = (RCW > CCW) ? RCW : CCW;
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW    = ggma_pkg::SCORE_W;
   localparam int NW    = ggma_pkg::CNT_W;

   // configuration registers
   logic [ggma_pkg::DIM_W-1:0] num_rows_ff;
   logic [ggma_pkg::DIM_W-1:0] num_cols_ff;
   logic [SW-1:0]              gate_ff;

   // run state
   ggma_pkg::ggma_state_type state_ff, state_in;
   logic [RCW-1:0]      rows_ff;
   logic [CCW-1:0]      cols_ff;
   logic [NW-1:0]       limit_ff;
   logic [NW-1:0]       cnt_ff;
   logic [MAX_ROWS-1:0] row_used_ff;
   logic [MAX_COLS-1:0] col_used_ff;
   logic [RW-1:0]       row_ff;
   logic [CW-1:0]       col_ff;

   // read pipeline tag and running minimum
   logic          tag_vld_ff;
   logic [RW-1:0] tag_r_ff;
   logic [CW-1:0] tag_c_ff;
   logic [SW-1:0] rd_data_ff;
   logic          best_have_ff;
   logic [SW-1:0] best_v_ff;
   logic [RW-1:0] best_r_ff;
   logic [CW-1:0] best_c_ff;

   // match waiting for its last flag
   logic          pend_vld_ff;
   logic [RW-1:0] pend_r_ff;
   logic [CW-1:0] pend_c_ff;

   // output register
   logic                       rsp_valid_ff;
   logic [ggma_pkg::SEL_W-1:0] rsp_row_ff;
   logic [ggma_pkg::SEL_W-1:0] rsp_col_ff;
   logic                       rsp_found_ff;
   logic [NW-1:0]              rsp_cnt_ff;
   logic                       rsp_last_ff;

   // score memory
   logic [SW-1:0] score_mem [DEPTH];

   // control
   logic req_take, start, load_we;
   logic out_free, need_emit, take_last;
   logic issue, pass_clr, take_best, emit, emit_pend, emit_last;
   logic row_end, col_end, hit;
   logic [RCW-1:0] rows_sat;
   logic [CCW-1:0] cols_sat;
   logic [LW-1:0]  lim_rc;
   logic [NW-1:0]  limit_calc;
   logic [AW-1:0]  ld_addr, rd_addr;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ggma_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign start     = req_take && (req_cmd == ggma_pkg::CMD_START);
   assign load_we   = req_take && (req_cmd == ggma_pkg::CMD_LOAD) &&
                      (32'(req_row_sel) < MAX_ROWS) && (32'(req_col_sel) < MAX_COLS);

   // dimensions saturated to the matrix bounds, limit = min(rows, cols, result cap)
   assign rows_sat   = (32'(num_rows_ff) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(num_rows_ff);
   assign cols_sat   = (32'(num_cols_ff) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(num_cols_ff);
   assign lim_rc     = (LW'(rows_sat) < LW'(cols_sat)) ? LW'(rows_sat) : LW'(cols_sat);
   assign limit_calc = (32'(lim_rc) > ggma_pkg::GGMA_MAX_RESULTS) ?
                       NW'(ggma_pkg::GGMA_MAX_RESULTS) : NW'(lim_rc);

   // memory addresses, row-major
   assign ld_addr = AW'(AW'(req_row_sel) * AW'(MAX_COLS) + AW'(req_col_sel));
   assign rd_addr = AW'(AW'(row_ff) * AW'(MAX_COLS) + AW'(col_ff));

   assign row_end   = (RCW'(row_ff) + RCW'(1)) == rows_ff;
   assign col_end   = (CCW'(col_ff) + CCW'(1)) == cols_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign need_emit = pend_vld_ff || !best_have_ff;
   assign take_last = (cnt_ff + NW'(1)) == limit_ff;

   // candidate check on the word coming back from memory
   assign hit = tag_vld_ff && !row_used_ff[tag_r_ff] && !col_used_ff[tag_c_ff] &&
                (rd_data_ff < gate_ff) && (!best_have_ff || rd_data_ff < best_v_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ggma_pkg::ST_IDLE: begin
            if (start) begin
               state_in = (limit_calc == '0) ? ggma_pkg::ST_DECIDE : ggma_pkg::ST_SCAN;
            end
         end
         ggma_pkg::ST_SCAN: begin
            if (row_end && col_end) begin
               state_in = ggma_pkg::ST_TAIL;
            end
         end
         ggma_pkg::ST_TAIL: begin
            state_in = ggma_pkg::ST_DECIDE;
         end
         ggma_pkg::ST_DECIDE: begin
            if (!need_emit || out_free) begin
               if (!best_have_ff) begin
                  state_in = ggma_pkg::ST_IDLE;
               end else if (take_last) begin
                  state_in = ggma_pkg::ST_FINAL;
               end else begin
                  state_in = ggma_pkg::ST_SCAN;
               end
            end
         end
         ggma_pkg::ST_FINAL: begin
            if (out_free) begin
               state_in = ggma_pkg::ST_IDLE;
            end
         end
         default: state_in = ggma_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      issue     = 1'b0;
      pass_clr  = 1'b0;
      take_best = 1'b0;
      emit      = 1'b0;
      emit_pend = 1'b0;
      emit_last = 1'b0;
      unique case (state_ff)
         ggma_pkg::ST_IDLE: begin
            pass_clr = start;
         end
         ggma_pkg::ST_SCAN: begin
            issue = 1'b1;
         end
         ggma_pkg::ST_TAIL: begin
            issue = 1'b0;
         end
         ggma_pkg::ST_DECIDE: begin
            if (!need_emit || out_free) begin
               emit      = need_emit;
               emit_pend = pend_vld_ff;
               emit_last = !best_have_ff;
               take_best = best_have_ff;
               pass_clr  = best_have_ff && !take_last;
            end
         end
         ggma_pkg::ST_FINAL: begin
            emit      = out_free;
            emit_pend = 1'b1;
            emit_last = 1'b1;
         end
         default: issue = 1'b0;
      endcase
   end

   // score memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (load_we) begin
         score_mem[ld_addr] <= req_score;
      end
      rd_data_ff <= score_mem[rd_addr];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= '0;
         num_cols_ff <= '0;
         gate_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ggma_pkg::CSR_NUM_ROWS:   num_rows_ff <= csr_wdata[ggma_pkg::DIM_W-1:0];
            ggma_pkg::CSR_NUM_COLS:   num_cols_ff <= csr_wdata[ggma_pkg::DIM_W-1:0];
            ggma_pkg::CSR_MATCH_GATE: gate_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // run control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ggma_pkg::ST_IDLE;
         tag_vld_ff   <= 1'b0;
         best_have_ff <= 1'b0;
         pend_vld_ff  <= 1'b0;
         cnt_ff       <= '0;
         row_used_ff  <= '0;
         col_used_ff  <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         tag_vld_ff <= issue;
         if (start) begin
            cnt_ff      <= '0;
            pend_vld_ff <= 1'b0;
            row_used_ff <= '0;
            col_used_ff <= '0;
         end
         if (take_best) begin
            cnt_ff                 <= cnt_ff + NW'(1);
            pend_vld_ff            <= 1'b1;
            row_used_ff[best_r_ff] <= 1'b1;
            col_used_ff[best_c_ff] <= 1'b1;
         end
         // pass address walk, row-major
         if (pass_clr) begin
            row_ff       <= '0;
            col_ff       <= '0;
            best_have_ff <= 1'b0;
         end else begin
            if (issue) begin
               if (col_end) begin
                  col_ff <= '0;
                  row_ff <= row_ff + RW'(1);
               end else begin
                  col_ff <= col_ff + CW'(1);
               end
            end
            if (hit) begin
               best_have_ff <= 1'b1;
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (start) begin
         rows_ff  <= rows_sat;
         cols_ff  <= cols_sat;
         limit_ff <= limit_calc;
      end
      tag_r_ff <= row_ff;
      tag_c_ff <= col_ff;
      if (hit) begin
         best_v_ff <= rd_data_ff;
         best_r_ff <= tag_r_ff;
         best_c_ff <= tag_c_ff;
      end
      if (take_best) begin
         pend_r_ff <= best_r_ff;
         pend_c_ff <= best_c_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_row_ff   <= emit_pend ? ggma_pkg::SEL_W'(pend_r_ff) : '0;
         rsp_col_ff   <= emit_pend ? ggma_pkg::SEL_W'(pend_c_ff) : '0;
         rsp_found_ff <= emit_pend;
         rsp_cnt_ff   <= emit_pend ? cnt_ff : '0;
         rsp_last_ff  <= emit_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_row   = rsp_row_ff;
   assign rsp_match_col   = rsp_col_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_count = rsp_cnt_ff;
   assign rsp_last        = rsp_last_ff;

   // checks
   `GGMA_ASSERT_IMP(a_cnt_le_limit, clock, reset, state_ff != ggma_pkg::ST_IDLE,
      cnt_ff <= limit_ff, "match count passed the run limit")
   `GGMA_ASSERT_IMP(a_marks_track_cnt, clock, reset, 1'b1,
      ($countones(row_used_ff) == 32'(cnt_ff)) && ($countones(col_used_ff) == 32'(cnt_ff)),
      "used marks out of step with match count")
   `GGMA_ASSERT_IMP(a_emit_free, clock, reset, emit,
      !rsp_valid_ff || !rsp_stall, "result register overwritten while stalled")
   `GGMA_ASSERT_IMP(a_nomatch_form, clock, reset, rsp_valid_ff && !rsp_found_ff,
      rsp_last_ff && (rsp_cnt_ff == '0), "no-match result not final or has a count")
   `GGMA_ASSERT_NXT(a_tag_in_scan, clock, reset, issue,
      tag_vld_ff && (state_ff == ggma_pkg::ST_SCAN || state_ff == ggma_pkg::ST_TAIL),
      "read data returned outside a pass")

endmodule
